[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/yc2rgb_pkg.sv]
// ---------------------------------------------------------------------------
// yc2rgb_pkg
// Word types, term widths and chroma term tables for the 4:2:0 to RGB555
// converter.
// ---------------------------------------------------------------------------
package yc2rgb_pkg;

  localparam int SampleW = 8;
  localparam int LumaW   = 14;   // expanded luma (y << 6) | (y >> 2)
  localparam int TermW   = 16;   // signed chroma term
  localparam int SumW    = 17;   // signed luma + term
  localparam int ChanW   = 5;
  localparam int PixW    = 3 * ChanW;
  localparam int RomN    = 1 << SampleW;

  // Fixed-point coefficients, scaled by COEF_SCALE.
  localparam longint COEF_SCALE = 100000;
  localparam longint COEF_VR    = 4536400;
  localparam longint COEF_UB    = 5720400;
  localparam longint COEF_VG    = -2335248;
  localparam longint COEF_UG    = -1151248;
  localparam longint TERM_BIAS  = 32;
  localparam int     CH_SHIFT   = 9;

  typedef logic signed [TermW-1:0] term_t;
  typedef term_t term_rom_t [RomN];

  typedef struct packed {
    logic [SampleW-1:0] chroma_u;
    logic [SampleW-1:0] chroma_v;
    logic [SampleW-1:0] luma_top_left;
    logic [SampleW-1:0] luma_top_right;
    logic [SampleW-1:0] luma_bottom_left;
    logic [SampleW-1:0] luma_bottom_right;
  } blk_word_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_top_left;
    logic [PixW-1:0] pixel_top_right;
    logic [PixW-1:0] pixel_bottom_left;
    logic [PixW-1:0] pixel_bottom_right;
  } pix_word_t;

  typedef struct packed {
    term_t tr;
    term_t tg;
    term_t tb;
  } terms_t;

  // trunc(coef * (2i - 255) / scale + bias), integer division rounds to zero
  function automatic term_rom_t build_rom(longint coef, longint bias);
    term_rom_t rom;
    longint    x;
    longint    n;
    for (int i = 0; i < RomN; i++) begin
      x      = 2 * longint'(i) - longint'(RomN - 1);
      n      = coef * x + bias * COEF_SCALE;
      rom[i] = TermW'(n / COEF_SCALE);
    end
    return rom;
  endfunction

  localparam term_rom_t ROM_R  = build_rom(COEF_VR, TERM_BIAS);
  localparam term_rom_t ROM_B  = build_rom(COEF_UB, TERM_BIAS);
  localparam term_rom_t ROM_GV = build_rom(COEF_VG, TERM_BIAS);
  localparam term_rom_t ROM_GU = build_rom(COEF_UG, 0);

endpackage

[rtl/ycbcr420_block_to_rgb555.sv]
// ---------------------------------------------------------------------------
// ycbcr420_block_to_rgb555
// 2x2 block of 4:2:0 YCbCr to four RGB555 pixels, BT.601 fixed point.
// ---------------------------------------------------------------------------
//
//  channel | signals                        | word
//  --------+--------------------------------+-------------------------------
//  src     | src_valid, src_stall, src_word | Cb, Cr and four luma samples
//  dst     | dst_valid, dst_stall, dst_word | four RGB555 pixels
//
//  One word per clock unless dst stalls; stage 1 feeds the merge register.
//  Stage 1 reads the chroma term tables; stage 2 runs four pixel lanes
//  side by side and the merge register packs their results.
//  rst (synchronous) empties both stages; payload registers are not reset.
//  A stalled dst holds its word while stage 1 still takes one new word;
//  src_stall rises only once both stages are full and dst is stalled.
//
module ycbcr420_block_to_rgb555 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  yc2rgb_pkg::blk_word_t src_word,
  output logic                  dst_valid,
  input  logic                  dst_stall,
  output yc2rgb_pkg::pix_word_t dst_word
);

  `include "assert_macros.svh"

  // Pipeline control
  logic s1_valid, s1_valid_next;
  logic dst_valid_next;
  logic s1_ready, s2_ready;
  logic s1_load, s2_load;

  // Stage 1 payload: lumas next to the registered chroma terms
  logic [yc2rgb_pkg::SampleW-1:0] luma [4];
  yc2rgb_pkg::terms_t             terms;
  logic [yc2rgb_pkg::PixW-1:0]    lane_px [4];

  assign s2_ready  = !dst_valid || !dst_stall;
  assign s1_ready  = !s1_valid || s2_ready;
  assign src_stall = !s1_ready;
  assign s1_load   = src_valid && s1_ready;
  assign s2_load   = s1_valid && s2_ready;

  always_comb begin
    s1_valid_next = s1_valid;
    if (s1_ready) begin
      s1_valid_next = src_valid;
    end
    dst_valid_next = dst_valid;
    if (s2_ready) begin
      dst_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      dst_valid <= dst_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      luma[0] <= src_word.luma_top_left;
      luma[1] <= src_word.luma_top_right;
      luma[2] <= src_word.luma_bottom_left;
      luma[3] <= src_word.luma_bottom_right;
    end
  end

  // Chroma terms shared by all four pixels
  yc2rgb_chroma u_chroma (
    .clk      (clk),
    .load     (s1_load),
    .chroma_u (src_word.chroma_u),
    .chroma_v (src_word.chroma_v),
    .terms    (terms)
  );

  // One lane per pixel of the block
  for (genvar k = 0; k < 4; k++) begin : g_lane
    yc2rgb_lane u_lane (
      .luma  (luma[k]),
      .terms (terms),
      .pixel (lane_px[k])
    );
  end

  yc2rgb_merge u_merge (
    .clk     (clk),
    .load    (s2_load),
    .lane_px (lane_px),
    .word    (dst_word)
  );

  // A word held in stage 1 behind a stalled output stays there
  `CHK_NEXT(a_s1_hold, s1_valid && !s2_ready, s1_valid, "stage 1 word lost")
  // Stage 1 empty never back-pressures the source
  `CHK_NOW(a_no_false_stall, !s1_valid, !src_stall, "stall with empty stage 1")
  // Output taken with nothing behind it leaves dst empty
  `CHK_NEXT(a_drain, dst_valid && !dst_stall && !s1_valid, !dst_valid,
            "output word repeated")
  // An accepted word reaches stage 1
  `CHK_NEXT(a_s1_fill, src_valid && !src_stall, s1_valid, "accepted word dropped")

endmodule

[rtl/yc2rgb_chroma.sv]
// ---------------------------------------------------------------------------
// yc2rgb_chroma
// Looks up the R, G and B chroma terms of one Cb/Cr pair and registers them.
// ---------------------------------------------------------------------------
module yc2rgb_chroma (
  input  logic                             clk,
  input  logic                             load,
  input  logic [yc2rgb_pkg::SampleW-1:0]   chroma_u,
  input  logic [yc2rgb_pkg::SampleW-1:0]   chroma_v,
  output yc2rgb_pkg::terms_t               terms
);

  yc2rgb_pkg::terms_t terms_next;

  always_comb begin
    terms_next.tr = yc2rgb_pkg::ROM_R[chroma_v];
    terms_next.tb = yc2rgb_pkg::ROM_B[chroma_u];
    // G takes both chroma samples
    terms_next.tg = yc2rgb_pkg::ROM_GV[chroma_v] + yc2rgb_pkg::ROM_GU[chroma_u];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms <= terms_next;
    end
  end

endmodule

[rtl/yc2rgb_lane.sv]
// ---------------------------------------------------------------------------
// yc2rgb_lane
// One pixel: expands luma, adds each chroma term to it, scales and clamps.
// ---------------------------------------------------------------------------
module yc2rgb_lane (
  input  logic [yc2rgb_pkg::SampleW-1:0] luma,
  input  yc2rgb_pkg::terms_t             terms,
  output logic [yc2rgb_pkg::PixW-1:0]    pixel
);

  logic [yc2rgb_pkg::LumaW-1:0] y_ext;
  logic [yc2rgb_pkg::ChanW-1:0] r_ch, g_ch, b_ch;

  // floor(sum / 512) clamped to 0..31; sum never reaches 2^15
  function automatic logic [yc2rgb_pkg::ChanW-1:0] chan(
    input logic [yc2rgb_pkg::LumaW-1:0] y,
    input yc2rgb_pkg::term_t            t
  );
    logic signed [yc2rgb_pkg::SumW-1:0] s;
    logic [yc2rgb_pkg::ChanW-1:0]       c;
    s = $signed({{(yc2rgb_pkg::SumW - yc2rgb_pkg::LumaW){1'b0}}, y})
      + {{(yc2rgb_pkg::SumW - yc2rgb_pkg::TermW){t[yc2rgb_pkg::TermW-1]}}, t};
    if (s[yc2rgb_pkg::SumW-1]) begin
      c = '0;
    end else if (|s[yc2rgb_pkg::SumW-2:yc2rgb_pkg::CH_SHIFT+yc2rgb_pkg::ChanW]) begin
      c = '1;
    end else begin
      c = s[yc2rgb_pkg::CH_SHIFT+yc2rgb_pkg::ChanW-1:yc2rgb_pkg::CH_SHIFT];
    end
    return c;
  endfunction

  assign y_ext = {luma, luma[yc2rgb_pkg::SampleW-1:2]};
  assign r_ch  = chan(y_ext, terms.tr);
  assign g_ch  = chan(y_ext, terms.tg);
  assign b_ch  = chan(y_ext, terms.tb);
  assign pixel = {r_ch, g_ch, b_ch};

endmodule

[rtl/yc2rgb_merge.sv]
// ---------------------------------------------------------------------------
// yc2rgb_merge
// Gathers the four lane pixels into the output word register.
// ---------------------------------------------------------------------------
module yc2rgb_merge (
  input  logic                          clk,
  input  logic                          load,
  input  logic [yc2rgb_pkg::PixW-1:0]   lane_px [4],
  output yc2rgb_pkg::pix_word_t         word
);

  yc2rgb_pkg::pix_word_t word_next;

  always_comb begin
    word_next.pixel_top_left     = lane_px[0];
    word_next.pixel_top_right    = lane_px[1];
    word_next.pixel_bottom_left  = lane_px[2];
    word_next.pixel_bottom_right = lane_px[3];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= word_next;
    end
  end

endmodule
